[rtl/php_pkg.sv]
// ----------------------------------------------------------------------------
// php_pkg
// shared types and constants of the packet header parser
// ----------------------------------------------------------------------------
`default_nettype none

package php_pkg;

	localparam int unsigned MTU_W      = 13;
	localparam int unsigned VARINT_W   = 28;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam logic [MTU_W-1:0] MAX_MTU       = 13'd4096;
	localparam logic [MTU_W-1:0] DATA_MTU_RST  = 13'd64;
	localparam logic [MTU_W-1:0] AUDIO_MTU_RST = 13'd1024;

	localparam logic [CFG_IDX_W-1:0] REG_DATA_MTU  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AUDIO_MTU = 2'd1;

	localparam logic [2:0] AUDIO_TYPE_HI = 3'b011;
	localparam int unsigned FLAG_FRAGMENT = 7;
	localparam int unsigned FLAG_FIRST    = 6;
	localparam int unsigned FLAG_RESERVED = 3;
	localparam logic [2:0] MAX_GROUPS = 3'd4;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	typedef enum logic [5:0] {
		PH_TYPE    = 6'b000001,
		PH_FLAGS   = 6'b000010,
		PH_SEQ     = 6'b000100,
		PH_LEN     = 6'b001000,
		PH_SECOND  = 6'b010000,
		PH_PAYLOAD = 6'b100000
	} phase_t;

	typedef struct packed {
		kind_t               kind;
		logic [6:0]          msg_type;
		logic [7:0]          flag_bits;
		logic [7:0]          seq_number;
		logic [MTU_W-1:0]    payload_length;
		logic [VARINT_W-1:0] total_or_offset;
		logic [7:0]          payload_byte;
		logic                packet_last;
	} result_t;

endpackage

`default_nettype wire

[rtl/php_skid.sv]
// ----------------------------------------------------------------------------
// php_skid
// result register with a skid stage, so the parser keeps taking bytes
// while a result waits downstream
// ----------------------------------------------------------------------------
`default_nettype none

module php_skid (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             res_valid,
	input  wire php_pkg::result_t res_data,
	output logic                  full,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output php_pkg::result_t      out_data
);

	logic             out_valid_q;
	logic             skid_full_q;
	php_pkg::result_t out_data_q;
	php_pkg::result_t skid_data_q;
	logic             take;
	logic             load_out;
	logic             load_skid;

	assign take      = out_valid_q && !out_stall;
	assign load_out  = skid_full_q ? take : (res_valid && (!out_valid_q || take));
	assign load_skid = !skid_full_q && res_valid && out_valid_q && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else begin
			if (load_out)
				out_valid_q <= 1'b1;
			else if (take)
				out_valid_q <= 1'b0;
			if (load_skid)
				skid_full_q <= 1'b1;
			else if (take)
				skid_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out)
			out_data_q <= skid_full_q ? skid_data_q : res_data;
		if (load_skid)
			skid_data_q <= res_data;
	end

	assign full      = skid_full_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

[rtl/packet_header_parser.sv]
// ----------------------------------------------------------------------------
// packet_header_parser
// each result is registered, in the output register or the skid stage, after its byte transfer
// takes one byte per cycle while in_stall is low; the header state updates with each accepted byte
// a result waiting downstream parks in a skid stage; input stalls only when full
// reset clears the parse state and loads mtu defaults of 64 (data) and 1024 (audio)
// ----------------------------------------------------------------------------
`default_nettype none

module packet_header_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [12:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_transfer,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       kind,
	output logic [6:0]       msg_type,
	output logic [7:0]       flag_bits,
	output logic [7:0]       seq_number,
	output logic [12:0]      payload_length,
	output logic [27:0]      total_or_offset,
	output logic [7:0]       payload_byte,
	output logic             packet_last
);

	logic [12:0]       data_mtu_q, audio_mtu_q;
	php_pkg::phase_t   phase_q, phase_d;
	logic [7:0]        type_q, type_d;
	logic [7:0]        flags_q, flags_d;
	logic [7:0]        seq_q, seq_d;
	logic [27:0]       accum_q, accum_d;
	logic [2:0]        groups_q, groups_d;
	logic [3:0]        hdr_bytes_q, hdr_bytes_d;
	logic [27:0]       len_q, len_d;
	logic [12:0]       left_q, left_d;
	logic              drop_q, drop_d;

	logic              accept;
	logic              eot;
	logic [27:0]       shifted;
	logic [27:0]       accum_new;
	logic [2:0]        groups_inc;
	logic [3:0]        hdr_inc;
	logic [27:0]       fin_len;
	logic [28:0]       pkt_size;
	logic [12:0]       mtu_raw, mtu;
	logic              hdr_ok;
	logic              res_valid;
	php_pkg::result_t  res;
	php_pkg::result_t  err_res;
	php_pkg::result_t  out_data;
	logic              skid_full;

	assign accept = in_valid && !in_stall;
	assign eot    = end_of_transfer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_mtu_q  <= php_pkg::DATA_MTU_RST;
			audio_mtu_q <= php_pkg::AUDIO_MTU_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				php_pkg::REG_DATA_MTU:  data_mtu_q  <= cfg_data;
				php_pkg::REG_AUDIO_MTU: audio_mtu_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// 7-bit group placement
	always_comb begin
		unique case (groups_q[1:0])
			2'd0: shifted = {21'd0, data_byte[6:0]};
			2'd1: shifted = {14'd0, data_byte[6:0], 7'd0};
			2'd2: shifted = {7'd0, data_byte[6:0], 14'd0};
			default: shifted = {data_byte[6:0], 21'd0};
		endcase
	end

	assign accum_new  = accum_q | shifted;
	assign groups_inc = groups_q + 3'd1;
	assign hdr_inc    = hdr_bytes_q + 4'd1;
	assign fin_len    = (phase_q == php_pkg::PH_SECOND) ? len_q : accum_new;
	assign pkt_size   = {25'd0, hdr_inc} + {1'b0, fin_len};
	assign mtu_raw    = (type_q[7:5] == php_pkg::AUDIO_TYPE_HI) ? audio_mtu_q : data_mtu_q;
	assign mtu        = (mtu_raw > php_pkg::MAX_MTU) ? php_pkg::MAX_MTU : mtu_raw;
	assign hdr_ok     = !type_q[7] && (data_byte != 8'd0) &&
		!flags_q[php_pkg::FLAG_RESERVED] &&
		(!flags_q[php_pkg::FLAG_FIRST] || flags_q[php_pkg::FLAG_FRAGMENT]);

	always_comb begin
		err_res             = '0;
		err_res.kind        = php_pkg::KIND_ERROR;
		err_res.packet_last = 1'b1;
	end

	always_comb begin
		phase_d     = phase_q;
		type_d      = type_q;
		flags_d     = flags_q;
		seq_d       = seq_q;
		accum_d     = accum_q;
		groups_d    = groups_q;
		hdr_bytes_d = hdr_bytes_q;
		len_d       = len_q;
		left_d      = left_q;
		drop_d      = drop_q;
		res_valid   = 1'b0;
		res                 = '0;
		res.msg_type        = type_q[6:0];
		res.flag_bits       = flags_q;
		res.seq_number      = seq_q;
		res.payload_length  = len_q[12:0];
		res.total_or_offset = flags_q[php_pkg::FLAG_FRAGMENT] ? accum_q : 28'd0;

		if (drop_q) begin
			if (eot) begin
				drop_d  = 1'b0;
				phase_d = php_pkg::PH_TYPE;
			end
		end else begin
			unique case (phase_q)
				php_pkg::PH_FLAGS: begin
					flags_d     = data_byte;
					hdr_bytes_d = 4'd2;
					if (eot) begin
						res_valid = 1'b1;
						res       = err_res;
						phase_d   = php_pkg::PH_TYPE;
					end else begin
						phase_d = php_pkg::PH_SEQ;
					end
				end
				php_pkg::PH_SEQ: begin
					seq_d       = data_byte;
					hdr_bytes_d = 4'd3;
					if (!hdr_ok || eot) begin
						res_valid = 1'b1;
						res       = err_res;
						phase_d   = php_pkg::PH_TYPE;
						drop_d    = !eot;
					end else begin
						accum_d  = '0;
						groups_d = '0;
						len_d    = '0;
						phase_d  = php_pkg::PH_LEN;
					end
				end
				php_pkg::PH_LEN, php_pkg::PH_SECOND: begin
					accum_d     = accum_new;
					groups_d    = groups_inc;
					hdr_bytes_d = hdr_inc;
					if (phase_q == php_pkg::PH_LEN)
						len_d = accum_new;
					if (data_byte[7]) begin
						if (groups_inc >= php_pkg::MAX_GROUPS || eot) begin
							res_valid = 1'b1;
							res       = err_res;
							phase_d   = php_pkg::PH_TYPE;
							drop_d    = !eot;
						end
					end else if (phase_q == php_pkg::PH_LEN &&
						flags_q[php_pkg::FLAG_FRAGMENT]) begin
						if (eot) begin
							res_valid = 1'b1;
							res       = err_res;
							phase_d   = php_pkg::PH_TYPE;
						end else begin
							accum_d  = '0;
							groups_d = '0;
							phase_d  = php_pkg::PH_SECOND;
						end
					end else begin
						// length, and the fragment offset if any, known
						res_valid = 1'b1;
						if (pkt_size > {16'd0, mtu}) begin
							res     = err_res;
							phase_d = php_pkg::PH_TYPE;
							drop_d  = !eot;
						end else if (fin_len == 28'd0) begin
							res.kind            = php_pkg::KIND_HEADER;
							res.payload_length  = 13'd0;
							res.total_or_offset = flags_q[php_pkg::FLAG_FRAGMENT] ?
								accum_new : 28'd0;
							res.packet_last     = 1'b1;
							phase_d             = php_pkg::PH_TYPE;
						end else if (eot) begin
							res     = err_res;
							phase_d = php_pkg::PH_TYPE;
						end else begin
							left_d              = fin_len[12:0];
							res.kind            = php_pkg::KIND_HEADER;
							res.payload_length  = fin_len[12:0];
							res.total_or_offset = flags_q[php_pkg::FLAG_FRAGMENT] ?
								accum_new : 28'd0;
							phase_d             = php_pkg::PH_PAYLOAD;
						end
					end
				end
				php_pkg::PH_PAYLOAD: begin
					res_valid = 1'b1;
					if (left_q > 13'd1) begin
						if (eot) begin
							res     = err_res;
							phase_d = php_pkg::PH_TYPE;
						end else begin
							left_d           = left_q - 13'd1;
							res.kind         = php_pkg::KIND_PAYLOAD;
							res.payload_byte = data_byte;
						end
					end else begin
						left_d           = '0;
						res.kind         = php_pkg::KIND_PAYLOAD;
						res.payload_byte = data_byte;
						res.packet_last  = 1'b1;
						phase_d          = php_pkg::PH_TYPE;
					end
				end
				default: begin
					type_d      = data_byte;
					flags_d     = '0;
					seq_d       = '0;
					len_d       = '0;
					accum_d     = '0;
					groups_d    = '0;
					hdr_bytes_d = 4'd1;
					if (eot) begin
						res_valid = 1'b1;
						res       = err_res;
						phase_d   = php_pkg::PH_TYPE;
					end else begin
						phase_d = php_pkg::PH_FLAGS;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= php_pkg::PH_TYPE;
			type_q      <= '0;
			flags_q     <= '0;
			seq_q       <= '0;
			accum_q     <= '0;
			groups_q    <= '0;
			hdr_bytes_q <= '0;
			len_q       <= '0;
			left_q      <= '0;
			drop_q      <= 1'b0;
		end else if (accept) begin
			phase_q     <= phase_d;
			type_q      <= type_d;
			flags_q     <= flags_d;
			seq_q       <= seq_d;
			accum_q     <= accum_d;
			groups_q    <= groups_d;
			hdr_bytes_q <= hdr_bytes_d;
			len_q       <= len_d;
			left_q      <= left_d;
			drop_q      <= drop_d;
		end
	end

	php_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (accept && res_valid),
		.res_data  (res),
		.full      (skid_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign in_stall        = skid_full;
	assign kind            = out_data.kind;
	assign msg_type        = out_data.msg_type;
	assign flag_bits       = out_data.flag_bits;
	assign seq_number      = out_data.seq_number;
	assign payload_length  = out_data.payload_length;
	assign total_or_offset = out_data.total_or_offset;
	assign payload_byte    = out_data.payload_byte;
	assign packet_last     = out_data.packet_last;

endmodule

`default_nettype wire

[tb/packet_header_parser_test.sv]
// ----------------------------------------------------------------------------
// packet_header_parser_test
// self-checking bench for the packet header parser: byte transfers enter
// through a sender with random gaps, a behavioral parser predicts every
// result, and each output transfer is compared in order, field by field
// ----------------------------------------------------------------------------
`default_nettype none

module packet_header_parser_test;

	import php_pkg::*;

	typedef logic [7:0] byte_q_t[$];

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_ITEMS = 1100;

	logic        clk             = 1'b0;
	logic        arst_n          = 1'b0;
	logic        cfg_write       = 1'b0;
	logic [1:0]  cfg_index       = '0;
	logic [12:0] cfg_data        = '0;
	logic        in_valid        = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte       = '0;
	logic        end_of_transfer = 1'b0;
	logic        out_valid;
	logic        out_stall       = 1'b0;
	logic [1:0]  kind;
	logic [6:0]  msg_type;
	logic [7:0]  flag_bits;
	logic [7:0]  seq_number;
	logic [12:0] payload_length;
	logic [27:0] total_or_offset;
	logic [7:0]  payload_byte;
	logic        packet_last;

	int unsigned src_idle_pct   = 16;
	int unsigned sink_stall_pct = 16;
	int unsigned hold_left      = 0;
	int unsigned mismatches     = 0;
	int unsigned bytes_sent     = 0;

	// behavioral parser state
	phase_t      parse_at      = PH_TYPE;
	logic [7:0]  cur_type      = '0;
	logic [7:0]  cur_flags     = '0;
	logic [7:0]  cur_seq       = '0;
	logic [27:0] group_accum   = '0;
	logic [2:0]  groups_seen   = '0;
	logic [3:0]  hdr_count     = '0;
	logic [27:0] len_field     = '0;
	logic [12:0] bytes_to_go   = '0;
	logic        skipping      = 1'b0;
	logic [12:0] data_mtu_cfg  = DATA_MTU_RST;
	logic [12:0] audio_mtu_cfg = AUDIO_MTU_RST;

	result_t pending_results[$];
	result_t want_result;

	packet_header_parser uut (.*);

	always #5 clk = ~clk;

	// receiver: random stalls, or a long hold-off while hold_left runs down
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall = ($urandom_range(99) < sink_stall_pct);
		end
	end

	function automatic int unsigned mtu_limit(input logic [7:0] ptype);
		int unsigned m;
		m = (ptype[7:5] == AUDIO_TYPE_HI) ? audio_mtu_cfg : data_mtu_cfg;
		return (m > MAX_MTU) ? MAX_MTU : m;
	endfunction

	task automatic expect_result(input kind_t k, input logic [7:0] value, input logic last);
		result_t r;
		r.kind            = k;
		r.msg_type        = cur_type[6:0];
		r.flag_bits       = cur_flags;
		r.seq_number      = cur_seq;
		r.payload_length  = len_field[12:0];
		r.total_or_offset = cur_flags[FLAG_FRAGMENT] ? group_accum : '0;
		r.payload_byte    = value;
		r.packet_last     = last;
		pending_results.push_back(r);
	endtask

	task automatic expect_error(input logic eot);
		result_t r;
		r = '0;
		r.kind = KIND_ERROR;
		r.packet_last = 1'b1;
		pending_results.push_back(r);
		parse_at = PH_TYPE;
		skipping = !eot;
	endtask

	task automatic close_header(input logic eot);
		if (32'(hdr_count) + 32'(len_field) > mtu_limit(cur_type)) begin
			expect_error(eot);
		end else if (len_field == '0) begin
			expect_result(KIND_HEADER, 8'h00, 1'b1);
			parse_at = PH_TYPE;
		end else if (eot) begin
			expect_error(eot);
		end else begin
			bytes_to_go = len_field[12:0];
			expect_result(KIND_HEADER, 8'h00, 1'b0);
			parse_at = PH_PAYLOAD;
		end
	endtask

	task automatic predict_byte(input logic [7:0] b, input logic eot);
		if (skipping) begin
			if (eot) begin
				skipping = 1'b0;
				parse_at = PH_TYPE;
			end
			return;
		end
		case (parse_at)
			PH_FLAGS: begin
				cur_flags = b;
				hdr_count = 4'd2;
				if (eot) expect_error(eot);
				else parse_at = PH_SEQ;
			end
			PH_SEQ: begin
				cur_seq = b;
				hdr_count = 4'd3;
				if (cur_type[7] || b == 8'h00 || cur_flags[FLAG_RESERVED] ||
				    (cur_flags[FLAG_FIRST] && !cur_flags[FLAG_FRAGMENT]) || eot) begin
					expect_error(eot);
				end else begin
					group_accum = '0;
					groups_seen = '0;
					len_field = '0;
					parse_at = PH_LEN;
				end
			end
			PH_LEN, PH_SECOND: begin
				group_accum = group_accum | (28'(b[6:0]) << (7 * groups_seen[1:0]));
				groups_seen = groups_seen + 3'd1;
				hdr_count = hdr_count + 4'd1;
				if (b[7]) begin
					if (groups_seen >= MAX_GROUPS || eot) expect_error(eot);
				end else if (parse_at == PH_LEN && cur_flags[FLAG_FRAGMENT]) begin
					len_field = group_accum;
					if (eot) begin
						expect_error(eot);
					end else begin
						group_accum = '0;
						groups_seen = '0;
						parse_at = PH_SECOND;
					end
				end else begin
					if (parse_at == PH_LEN) len_field = group_accum;
					close_header(eot);
				end
			end
			PH_PAYLOAD: begin
				if (bytes_to_go > 13'd1) begin
					if (eot) begin
						expect_error(eot);
					end else begin
						bytes_to_go = bytes_to_go - 13'd1;
						expect_result(KIND_PAYLOAD, b, 1'b0);
					end
				end else begin
					bytes_to_go = '0;
					expect_result(KIND_PAYLOAD, b, 1'b1);
					parse_at = PH_TYPE;
				end
			end
			default: begin
				cur_type = b;
				cur_flags = '0;
				cur_seq = '0;
				len_field = '0;
				group_accum = '0;
				groups_seen = '0;
				hdr_count = 4'd1;
				if (eot) expect_error(eot);
				else parse_at = PH_FLAGS;
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [27:0] want, input logic [27:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got kind %0d last %0d",
					$time, kind, packet_last);
				mismatches++;
			end else begin
				want_result = pending_results.pop_front();
				check_field("kind", 28'(want_result.kind), 28'(kind));
				check_field("msg_type", 28'(want_result.msg_type), 28'(msg_type));
				check_field("flag_bits", 28'(want_result.flag_bits), 28'(flag_bits));
				check_field("seq_number", 28'(want_result.seq_number), 28'(seq_number));
				check_field("payload_length", 28'(want_result.payload_length),
					28'(payload_length));
				check_field("total_or_offset", want_result.total_or_offset, total_or_offset);
				check_field("payload_byte", 28'(want_result.payload_byte), 28'(payload_byte));
				check_field("packet_last", 28'(want_result.packet_last), 28'(packet_last));
			end
		end
	end

	// called at a falling edge, returns at a falling edge with valid low
	task automatic send_byte(input logic [7:0] value, input logic last);
		while ($urandom_range(99) < src_idle_pct) @(negedge clk);
		in_valid = 1'b1;
		data_byte = value;
		end_of_transfer = last;
		do @(posedge clk); while (in_stall !== 1'b0);
		predict_byte(value, last);
		bytes_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic send_frame(input byte_q_t frame, input logic eot_last);
		foreach (frame[i]) send_byte(frame[i], eot_last && (i == frame.size() - 1));
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [12:0] value);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_write = 1'b0;
		case (idx)
			REG_DATA_MTU:  data_mtu_cfg = value;
			REG_AUDIO_MTU: audio_mtu_cfg = value;
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	// little-endian 7-bit groups, padded to the requested group count
	task automatic push_varint(ref byte_q_t q, input int unsigned value, input int unsigned groups);
		int unsigned n;
		n = 1;
		while (n < 4 && (value >> (7 * n)) != 0) n++;
		if (groups > n) n = (groups > 4) ? 4 : groups;
		for (int unsigned g = 0; g < n; g++)
			q.push_back({(g + 1 < n), 7'((value >> (7 * g)) & 32'h7f)});
	endtask

	function automatic int unsigned pick_groups();
		return ($urandom_range(99) < 25) ? $urandom_range(1, 4) : 1;
	endfunction

	task automatic build_random_packet(ref byte_q_t q);
		logic [7:0]  ptype;
		logic [7:0]  pflags;
		logic [7:0]  pseq;
		int unsigned len;
		int unsigned cap;
		int unsigned pick;
		int unsigned n_pay;
		ptype = 8'($urandom_range(0, 127));
		if ($urandom_range(99) < 6) ptype[7] = 1'b1;
		pflags = 8'($urandom_range(0, 255));
		if ($urandom_range(99) < 92) begin
			pflags[FLAG_RESERVED] = 1'b0;
			if (pflags[FLAG_FIRST]) pflags[FLAG_FRAGMENT] = 1'b1;
		end
		pseq = 8'($urandom_range(1, 255));
		if ($urandom_range(99) < 4) pseq = 8'h00;
		cap = mtu_limit(ptype);
		pick = $urandom_range(99);
		if (pick < 55) len = $urandom_range(0, 12);
		else if (pick < 80) len = $urandom_range(0, 64);
		else if (pick < 95 && cap <= 256) len = ((cap > 10) ? cap - 10 : 0) + $urandom_range(0, 8);
		else if (pick < 95) len = $urandom_range(0, 12);
		else len = ($urandom() >> $urandom_range(4, 31)) & 32'h0fff_ffff;
		q.push_back(ptype);
		q.push_back(pflags);
		q.push_back(pseq);
		if ($urandom_range(99) < 4) begin
			// length that runs past the last group
			repeat (4) q.push_back(8'($urandom_range(128, 255)));
			return;
		end
		push_varint(q, len, pick_groups());
		if (pflags[FLAG_FRAGMENT])
			push_varint(q, ($urandom() >> $urandom_range(4, 31)) & 32'h0fff_ffff, pick_groups());
		n_pay = (len > 300) ? $urandom_range(0, 4) : len;
		repeat (n_pay) q.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic send_random_transfer();
		byte_q_t     frame;
		int unsigned packets;
		int unsigned cut;
		packets = $urandom_range(1, 3);
		for (int unsigned p = 0; p < packets; p++) begin
			frame = {};
			build_random_packet(frame);
			if ($urandom_range(99) < 5) begin
				// transfer cut short somewhere inside the packet
				cut = $urandom_range(0, frame.size() - 1);
				frame = frame[0:cut];
				send_frame(frame, 1'b1);
				return;
			end
			send_frame(frame, p == packets - 1);
		end
	endtask

	task automatic test_header_checks();
		send_frame('{8'h00, 8'h00, 8'h01, 8'h00}, 1'b1);
		send_frame('{8'h7f, 8'hc0, 8'hff, 8'h03, 8'hff, 8'hff, 8'hff, 8'h7f,
			8'h00, 8'hff, 8'h5a}, 1'b1);
		// type out of range, zero sequence, reserved flag, first without fragment
		send_frame('{8'h80, 8'h00, 8'h01, 8'h55}, 1'b1);
		send_frame('{8'h01, 8'h00, 8'h00, 8'h55}, 1'b1);
		send_frame('{8'h01, 8'h08, 8'h01, 8'h00}, 1'b1);
		send_frame('{8'h01, 8'h40, 8'h01, 8'h00}, 1'b1);
	endtask

	task automatic test_early_end();
		send_frame('{8'h05}, 1'b1);
		send_frame('{8'h05, 8'h00}, 1'b1);
		send_frame('{8'h05, 8'h00, 8'h01}, 1'b1);
		send_frame('{8'h05, 8'h00, 8'h01, 8'h81}, 1'b1);
		send_frame('{8'h05, 8'h80, 8'h01, 8'h02}, 1'b1);
		send_frame('{8'h05, 8'h80, 8'h01, 8'h02, 8'h83}, 1'b1);
		send_frame('{8'h05, 8'h80, 8'h01, 8'h00, 8'h07}, 1'b1);
		send_frame('{8'h05, 8'h00, 8'h01, 8'h02}, 1'b1);
		send_frame('{8'h05, 8'h00, 8'h01, 8'h03, 8'haa, 8'hbb}, 1'b1);
		send_frame('{8'h05, 8'h00, 8'h01, 8'h01, 8'hcc}, 1'b1);
		send_frame('{8'h05, 8'h00, 8'h00, 8'h11, 8'h22, 8'h33}, 1'b1);
		send_frame('{8'h06, 8'h00, 8'h02, 8'h01, 8'hdd}, 1'b1);
	endtask

	task automatic test_length_groups();
		send_frame('{8'h02, 8'h00, 8'h01, 8'hff, 8'hff, 8'hff, 8'hff, 8'h11}, 1'b1);
		send_frame('{8'h02, 8'h00, 8'h01, 8'h85, 8'h80, 8'h80, 8'h00,
			8'ha1, 8'ha2, 8'ha3, 8'ha4, 8'ha5}, 1'b1);
		send_frame('{8'h03, 8'h80, 8'h01, 8'h01, 8'h80, 8'h00, 8'hee}, 1'b1);
		send_frame('{8'h03, 8'h80, 8'h01, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00}, 1'b1);
	endtask

	// receiver holds off while a full-size data packet streams in
	task automatic test_receiver_hold();
		byte_q_t frame;
		frame = '{8'h10, 8'h00, 8'h2a, 8'd60};
		repeat (60) frame.push_back(8'($urandom_range(0, 255)));
		src_idle_pct = 0;
		@(posedge clk);
		hold_left = HOLD_CYCLES;
		@(negedge clk);
		send_frame(frame, 1'b1);
		src_idle_pct = 16;
	endtask

	task automatic test_mtu_limits();
		byte_q_t frame;
		wait_idle();
		write_reg(REG_DATA_MTU, 13'd4);
		write_reg(REG_AUDIO_MTU, 13'd4096);
		send_frame('{8'h01, 8'h00, 8'h01, 8'h00}, 1'b0);
		send_frame('{8'h01, 8'h00, 8'h01, 8'h01, 8'h77}, 1'b1);
		send_frame('{8'h01, 8'h80, 8'h01, 8'h00, 8'h00}, 1'b1);
		frame = '{8'h60, 8'h00, 8'h01, 8'hfb, 8'h1f};
		repeat (3) frame.push_back(8'($urandom_range(0, 255)));
		send_frame(frame, 1'b1);
		send_frame('{8'h60, 8'h00, 8'h01, 8'hfc, 8'h1f, 8'h00}, 1'b1);
		wait_idle();
		// above the largest packet size, acts as the largest
		write_reg(REG_DATA_MTU, 13'h1fff);
		write_reg(REG_AUDIO_MTU, 13'd4);
		send_frame('{8'h60, 8'h00, 8'h01, 8'h00}, 1'b0);
		send_frame('{8'h7f, 8'h00, 8'h01, 8'h01, 8'h33}, 1'b1);
		send_frame('{8'h00, 8'h00, 8'h01, 8'hfc, 8'h1f, 8'h00}, 1'b1);
		wait_idle();
		write_reg(REG_UNUSED, 13'd4);
		send_frame('{8'h00, 8'h00, 8'h01, 8'h05, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05}, 1'b1);
	endtask

	task automatic test_random_traffic();
		int unsigned target;
		for (int unsigned ph = 0; ph < 4; ph++) begin
			wait_idle();
			case (ph)
				0: begin
					write_reg(REG_DATA_MTU, 13'd4096);
					write_reg(REG_AUDIO_MTU, 13'd4096);
				end
				1: begin
					write_reg(REG_DATA_MTU, 13'($urandom_range(20, 80)));
					write_reg(REG_AUDIO_MTU, 13'($urandom_range(20, 80)));
				end
				default: begin
					write_reg(REG_DATA_MTU, 13'($urandom_range(16, 300)));
					write_reg(REG_AUDIO_MTU, 13'($urandom_range(4, 4096)));
				end
			endcase
			src_idle_pct = (ph == 2) ? 0 : 16;
			sink_stall_pct = (ph == 2) ? 0 : 16;
			target = bytes_sent + RANDOM_ITEMS / 4;
			while (bytes_sent < target) send_random_transfer();
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_header_checks();
		test_early_end();
		test_length_groups();
		test_receiver_hold();
		test_mtu_limits();
		test_random_traffic();
		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire
